@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the particle grid hash RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PGH_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("particle grid hash assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define PGH_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("particle grid hash assertion failed");

`endif

@@ rtl/core/pgh_pkg.sv @@
// ----------------------------------------------------------------------------
// pgh_pkg
// Types, register indexes and helpers shared by the particle grid hash RTL.
// ----------------------------------------------------------------------------
package pgh_pkg;

  // Configuration register index width and register map.
  localparam int CFG_IDX_W = 4;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_ORIGIN_X   = 4'd0;
  localparam cfg_idx_t REG_ORIGIN_Y   = 4'd1;
  localparam cfg_idx_t REG_ORIGIN_Z   = 4'd2;
  localparam cfg_idx_t REG_INV_CELL_X = 4'd3;
  localparam cfg_idx_t REG_INV_CELL_Y = 4'd4;
  localparam cfg_idx_t REG_INV_CELL_Z = 4'd5;
  localparam cfg_idx_t REG_AXIS_BITS  = 4'd6;
  localparam cfg_idx_t REG_TIME_STEP  = 4'd7;

  // Reset value of each reciprocal cell size register.
  localparam logic [31:0] INV_CELL_RESET = 32'h0001_0000;

  // Flag set in the top bit of the hash when the particle has expired.
  localparam logic [31:0] DEAD_FLAG = 32'h8000_0000;

  // Current contents of the configuration registers.
  typedef struct packed {
    logic [31:0] origin_x;
    logic [31:0] origin_y;
    logic [31:0] origin_z;
    logic [31:0] inv_cell_x;
    logic [31:0] inv_cell_y;
    logic [31:0] inv_cell_z;
    logic [11:0] axis_bits;
    logic [30:0] time_step;
  } cfg_regs_t;

  // Load enables of the four pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

  // Saturate a 4-bit axis width field to the supported maximum.
  function automatic logic [3:0] sat_axis_bits(input logic [3:0] field,
                                               input logic [3:0] limit);
    return (field > limit) ? limit : field;
  endfunction

endpackage

@@ rtl/core/particle_grid_hash.sv @@
// ----------------------------------------------------------------------------
// particle_grid_hash
// Uniform grid spatial hash: particle position to packed cell index.
// ----------------------------------------------------------------------------
// The block takes one particle per clock while pcl_stall is low and returns
// its packed cell index and updated lifetime. The four stages are the origin
// subtract, the 32 x 32 reciprocal multiply, the truncate and clamp, and the
// packing into the output register. Each stage advances whenever the stage
// after it is empty or moving, so bubbles close up and a stalled output only
// holds back the input once all four stages are full. Configuration writes
// are taken in every cycle and should only be issued while the pipeline is
// empty.
module particle_grid_hash #(
  parameter int FRAC_BITS     = 16,
  parameter int MAX_AXIS_BITS = 10
) (
  input  logic                     clk,
  input  logic                     rst,
  // Particle input channel.
  input  logic                     pcl_valid,
  output logic                     pcl_stall,
  input  logic [31:0]              pos_x,
  input  logic [31:0]              pos_y,
  input  logic [31:0]              pos_z,
  input  logic [31:0]              life_in,
  // Hash result channel.
  output logic                     hash_valid,
  input  logic                     hash_stall,
  output logic [31:0]              cell_hash,
  output logic [30:0]              life_out,
  // Configuration write channel.
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  pgh_pkg::cfg_idx_t        cfg_index,
  input  logic [31:0]              cfg_data
);

  `include "assert_macros.svh"

  pgh_pkg::cfg_regs_t       regs;
  pgh_pkg::stage_en_t       en;
  logic                     v1, v2, v3, v4;
  logic                     rdy1, rdy2, rdy3, rdy4;
  logic [3:0]               bx, by, bz;
  logic [32:0]              life_diff;
  logic [30:0]              life_next;
  logic [30:0]              life1, life2, life3;
  logic                     dead1, dead2, dead3;
  logic [MAX_AXIS_BITS-1:0] cx, cy, cz;

  // Configuration registers.
  pgh_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  // Axis widths, saturated to the supported maximum.
  assign bx = pgh_pkg::sat_axis_bits(regs.axis_bits[3:0],  4'(MAX_AXIS_BITS));
  assign bz = pgh_pkg::sat_axis_bits(regs.axis_bits[7:4],  4'(MAX_AXIS_BITS));
  assign by = pgh_pkg::sat_axis_bits(regs.axis_bits[11:8], 4'(MAX_AXIS_BITS));

  // Each stage loads when it is empty or its contents move on.
  assign rdy4 = !v4 || !hash_stall;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  assign en.s1 = rdy1;
  assign en.s2 = rdy2;
  assign en.s3 = rdy3;
  assign en.s4 = rdy4;

  assign pcl_stall  = !rdy1;
  assign hash_valid = v4;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en.s1) v1 <= pcl_valid;
      if (en.s2) v2 <= v1;
      if (en.s3) v3 <= v2;
      if (en.s4) v4 <= v3;
    end
  end

  // Lifetime update, floored at zero, then carried down the pipeline.
  assign life_diff = {life_in[31], life_in} - {2'b00, regs.time_step};
  assign life_next = life_diff[32] ? 31'd0 : life_diff[30:0];

  always_ff @(posedge clk) begin
    if (en.s1) begin
      life1 <= life_next;
      dead1 <= (life_next == 31'd0);
    end
    if (en.s2) begin
      life2 <= life1;
      dead2 <= dead1;
    end
    if (en.s3) begin
      life3 <= life2;
      dead3 <= dead2;
    end
  end

  // Per-axis cell coordinate pipelines.
  pgh_axis #(.FRAC_BITS(FRAC_BITS), .MAX_AXIS_BITS(MAX_AXIS_BITS)) u_axis_x (
    .clk    (clk),
    .en     (en),
    .pos    (pos_x),
    .origin (regs.origin_x),
    .inv    (regs.inv_cell_x),
    .bits   (bx),
    .coord  (cx)
  );

  pgh_axis #(.FRAC_BITS(FRAC_BITS), .MAX_AXIS_BITS(MAX_AXIS_BITS)) u_axis_y (
    .clk    (clk),
    .en     (en),
    .pos    (pos_y),
    .origin (regs.origin_y),
    .inv    (regs.inv_cell_y),
    .bits   (by),
    .coord  (cy)
  );

  pgh_axis #(.FRAC_BITS(FRAC_BITS), .MAX_AXIS_BITS(MAX_AXIS_BITS)) u_axis_z (
    .clk    (clk),
    .en     (en),
    .pos    (pos_z),
    .origin (regs.origin_z),
    .inv    (regs.inv_cell_z),
    .bits   (bz),
    .coord  (cz)
  );

  // Packing and output register.
  pgh_pack #(.MAX_AXIS_BITS(MAX_AXIS_BITS)) u_pack (
    .clk       (clk),
    .en        (en.s4),
    .cx        (cx),
    .cy        (cy),
    .cz        (cz),
    .bx        (bx),
    .bz        (bz),
    .life      (life3),
    .dead      (dead3),
    .cell_hash (cell_hash),
    .life_out  (life_out)
  );

  // The expiry flag always agrees with the delivered lifetime.
  `PGH_ASSERT_IMP(a_dead_flag, clk, rst, hash_valid, cell_hash[31] == (life_out == 31'd0))

  // The packed index never reaches bit 30.
  `PGH_ASSERT_IMP(a_bit30_clear, clk, rst, hash_valid, !cell_hash[30])

  // An accepted transaction always lands in the first stage.
  `PGH_ASSERT_NEXT(a_enter_s1, clk, rst, pcl_valid && !pcl_stall, v1)

  // Into an empty pipeline, a transaction reaches the output through stages one to four.
  `PGH_ASSERT_IMP(a_latency, clk, rst, pcl_valid && !pcl_stall && !v1 && !v2 && !v3 && !v4, ##4 hash_valid)

endmodule

@@ rtl/core/pgh_cfg.sv @@
// ----------------------------------------------------------------------------
// pgh_cfg
// Configuration register file; writes to unmapped indexes are dropped.
// ----------------------------------------------------------------------------
module pgh_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  pgh_pkg::cfg_idx_t   cfg_index,
  input  logic [31:0]         cfg_data,
  output pgh_pkg::cfg_regs_t  regs
);

  // The register file takes a write transaction in every cycle.
  assign cfg_ready = 1'b1;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.origin_x   <= '0;
      regs.origin_y   <= '0;
      regs.origin_z   <= '0;
      regs.inv_cell_x <= pgh_pkg::INV_CELL_RESET;
      regs.inv_cell_y <= pgh_pkg::INV_CELL_RESET;
      regs.inv_cell_z <= pgh_pkg::INV_CELL_RESET;
      regs.axis_bits  <= '0;
      regs.time_step  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pgh_pkg::REG_ORIGIN_X:   regs.origin_x   <= cfg_data;
        pgh_pkg::REG_ORIGIN_Y:   regs.origin_y   <= cfg_data;
        pgh_pkg::REG_ORIGIN_Z:   regs.origin_z   <= cfg_data;
        pgh_pkg::REG_INV_CELL_X: regs.inv_cell_x <= cfg_data;
        pgh_pkg::REG_INV_CELL_Y: regs.inv_cell_y <= cfg_data;
        pgh_pkg::REG_INV_CELL_Z: regs.inv_cell_z <= cfg_data;
        pgh_pkg::REG_AXIS_BITS:  regs.axis_bits  <= cfg_data[11:0];
        pgh_pkg::REG_TIME_STEP:  regs.time_step  <= cfg_data[30:0];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/core/pgh_axis.sv @@
// ----------------------------------------------------------------------------
// pgh_axis
// One axis of the cell lookup: subtract origin, scale, truncate and clamp.
// ----------------------------------------------------------------------------
module pgh_axis #(
  parameter int FRAC_BITS     = 16,
  parameter int MAX_AXIS_BITS = 10
) (
  input  logic                      clk,
  input  pgh_pkg::stage_en_t        en,
  input  logic [31:0]               pos,
  input  logic [31:0]               origin,
  input  logic [31:0]               inv,
  input  logic [3:0]                bits,
  output logic [MAX_AXIS_BITS-1:0]  coord
);

  localparam int SHIFT = 2 * FRAC_BITS;

  logic [32:0]              diff;
  logic                     positive;
  logic [31:0]              mag;
  logic [63:0]              prod_next;
  logic [63:0]              prod;
  logic [63:0]              quot;
  logic [63:0]              above;
  logic [MAX_AXIS_BITS-1:0] cell_pow;
  logic [MAX_AXIS_BITS-1:0] max_cell;
  logic [MAX_AXIS_BITS-1:0] coord_next;

  // Stage 1: exact 33-bit difference; non-positive distances map to cell 0.
  assign diff     = {pos[31], pos} - {origin[31], origin};
  assign positive = !diff[32] && (diff[31:0] != 32'd0);

  always_ff @(posedge clk) begin
    if (en.s1) begin
      mag <= positive ? diff[31:0] : 32'd0;
    end
  end

  // Stage 2: full 32 x 32 product with the reciprocal cell size.
  assign prod_next = 64'(mag) * 64'(inv);

  always_ff @(posedge clk) begin
    if (en.s2) begin
      prod <= prod_next;
    end
  end

  // Stage 3: drop both fraction fields and saturate to the last cell.
  assign quot       = prod >> SHIFT;
  assign above      = quot >> bits;
  assign cell_pow   = MAX_AXIS_BITS'(1) << bits;
  assign max_cell   = cell_pow - MAX_AXIS_BITS'(1);
  assign coord_next = (above != 64'd0) ? max_cell : quot[MAX_AXIS_BITS-1:0];

  always_ff @(posedge clk) begin
    if (en.s3) begin
      coord <= coord_next;
    end
  end

endmodule

@@ rtl/core/pgh_pack.sv @@
// ----------------------------------------------------------------------------
// pgh_pack
// Output stage: packs the three cell coordinates and the expiry flag.
// ----------------------------------------------------------------------------
module pgh_pack #(
  parameter int MAX_AXIS_BITS = 10
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [MAX_AXIS_BITS-1:0]  cx,
  input  logic [MAX_AXIS_BITS-1:0]  cy,
  input  logic [MAX_AXIS_BITS-1:0]  cz,
  input  logic [3:0]                bx,
  input  logic [3:0]                bz,
  input  logic [30:0]               life,
  input  logic                      dead,
  output logic [31:0]               cell_hash,
  output logic [30:0]               life_out
);

  logic [4:0]  y_shift;
  logic [31:0] packed_cell;

  // The x field sits at the bottom, then z, then y.
  assign y_shift     = 5'(bx) + 5'(bz);
  assign packed_cell = 32'(cx) | (32'(cz) << bx) | (32'(cy) << y_shift);

  // Output register; it holds while the consumer stalls.
  always_ff @(posedge clk) begin
    if (en) begin
      cell_hash <= dead ? (packed_cell | pgh_pkg::DEAD_FLAG) : packed_cell;
      life_out  <= life;
    end
  end

endmodule

@@ dv/particle_grid_hash_checker.sv @@
// ----------------------------------------------------------------------------
// particle_grid_hash_checker
// Watches the particle, hash and configuration channels of the grid hash,
// predicts the cell index and lifetime of every accepted particle and
// compares them with the hash results in order.
// ----------------------------------------------------------------------------
module particle_grid_hash_checker #(
  parameter int FRAC_BITS     = 16,
  parameter int MAX_AXIS_BITS = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              pcl_valid,
  input  logic              pcl_stall,
  input  logic [31:0]       pos_x,
  input  logic [31:0]       pos_y,
  input  logic [31:0]       pos_z,
  input  logic [31:0]       life_in,
  input  logic              hash_valid,
  input  logic              hash_stall,
  input  logic [31:0]       cell_hash,
  input  logic [30:0]       life_out,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  pgh_pkg::cfg_idx_t cfg_index,
  input  logic [31:0]       cfg_data,
  output int                mismatch_count,
  output int                pending_hashes
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] cell_hash;
    logic [30:0] life_out;
  } hash_result_t;

  // Local copy of the register file and the hashes still owed by the block.
  pgh_pkg::cfg_regs_t grid_cfg;
  hash_result_t       predicted_hashes[$];
  int                 mismatches = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s: got %h, predicted %h", $time, what, got, want);
    mismatches++;
  endtask

  // Clamp a 4-bit axis width field to the largest supported width.
  function automatic int unsigned axis_width(input logic [3:0] field);
    return (field > MAX_AXIS_BITS) ? MAX_AXIS_BITS : field;
  endfunction

  // Cell coordinate on one axis: truncated scaled offset, clamped to the grid.
  function automatic logic [31:0] axis_cell(input logic [31:0] pos,
                                            input logic [31:0] org,
                                            input logic [31:0] inv,
                                            input int unsigned bits);
    logic signed [32:0] diff;
    logic [63:0]        prod;
    logic [63:0]        scaled;
    logic [31:0]        last_cell;
    diff      = $signed({pos[31], pos}) - $signed({org[31], org});
    last_cell = (32'd1 << bits) - 32'd1;
    if (diff <= 0) return 32'd0;
    prod   = {32'd0, diff[31:0]} * {32'd0, inv};
    scaled = prod >> (2 * FRAC_BITS);
    return (scaled > {32'd0, last_cell}) ? last_cell : scaled[31:0];
  endfunction

  // Packed cell index and aged lifetime of one particle.
  function automatic hash_result_t hash_particle(input logic [31:0] px,
                                                 input logic [31:0] py,
                                                 input logic [31:0] pz,
                                                 input logic [31:0] life);
    int unsigned        bx, by, bz;
    logic [31:0]        cx, cy, cz, packed_cells;
    logic signed [32:0] aged;
    hash_result_t       res;
    bx   = axis_width(grid_cfg.axis_bits[3:0]);
    bz   = axis_width(grid_cfg.axis_bits[7:4]);
    by   = axis_width(grid_cfg.axis_bits[11:8]);
    cx   = axis_cell(px, grid_cfg.origin_x, grid_cfg.inv_cell_x, bx);
    cy   = axis_cell(py, grid_cfg.origin_y, grid_cfg.inv_cell_y, by);
    cz   = axis_cell(pz, grid_cfg.origin_z, grid_cfg.inv_cell_z, bz);
    aged = $signed({life[31], life}) - $signed({2'b00, grid_cfg.time_step});
    if (aged < 0) aged = '0;
    packed_cells = cx | (cz << bx) | (cy << (bx + bz));
    if (aged == 0) packed_cells = packed_cells | pgh_pkg::DEAD_FLAG;
    res.cell_hash = packed_cells;
    res.life_out  = aged[30:0];
    return res;
  endfunction

  // Sample every channel at the rising edge and track the block in order.
  always @(posedge clk) begin : watch
    hash_result_t want;
    if (rst) begin
      grid_cfg            = '0;
      grid_cfg.inv_cell_x = pgh_pkg::INV_CELL_RESET;
      grid_cfg.inv_cell_y = pgh_pkg::INV_CELL_RESET;
      grid_cfg.inv_cell_z = pgh_pkg::INV_CELL_RESET;
      predicted_hashes.delete();
    end else begin
      // Register writes land in the local copy; unmapped indexes are dropped.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pgh_pkg::REG_ORIGIN_X:   grid_cfg.origin_x   = cfg_data;
          pgh_pkg::REG_ORIGIN_Y:   grid_cfg.origin_y   = cfg_data;
          pgh_pkg::REG_ORIGIN_Z:   grid_cfg.origin_z   = cfg_data;
          pgh_pkg::REG_INV_CELL_X: grid_cfg.inv_cell_x = cfg_data;
          pgh_pkg::REG_INV_CELL_Y: grid_cfg.inv_cell_y = cfg_data;
          pgh_pkg::REG_INV_CELL_Z: grid_cfg.inv_cell_z = cfg_data;
          pgh_pkg::REG_AXIS_BITS:  grid_cfg.axis_bits  = cfg_data[11:0];
          pgh_pkg::REG_TIME_STEP:  grid_cfg.time_step  = cfg_data[30:0];
          default: ;
        endcase
      end
      // Each accepted particle transaction owes exactly one hash.
      if (pcl_valid && !pcl_stall) begin
        predicted_hashes.push_back(hash_particle(pos_x, pos_y, pos_z, life_in));
      end
      // Each accepted hash transaction settles the oldest prediction.
      if (hash_valid && !hash_stall) begin
        if (predicted_hashes.size() == 0) begin
          report_mismatch("hash with no particle waiting", cell_hash, 32'd0);
        end else begin
          want = predicted_hashes.pop_front();
          if (cell_hash !== want.cell_hash) begin
            report_mismatch("cell_hash", cell_hash, want.cell_hash);
          end
          if (life_out !== want.life_out) begin
            report_mismatch("life_out", {1'b0, life_out}, {1'b0, want.life_out});
          end
        end
      end
    end
    mismatch_count <= mismatches;
    pending_hashes <= predicted_hashes.size();
  end

endmodule

@@ dv/particle_grid_hash_tb.sv @@
// ----------------------------------------------------------------------------
// particle_grid_hash_tb
// Drives particles and register settings into the grid hash with random
// gaps and stalls on both channels; the checker beside the block predicts
// and compares every hash, and this top reports the verdict.
// ----------------------------------------------------------------------------
module particle_grid_hash_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                PIPE_LATENCY    = 4;
  localparam int                SETTLE_CYCLES   = PIPE_LATENCY + 6;
  localparam int                PHASES          = 9;
  localparam int                ITEMS_PER_PHASE = 205;
  localparam int                CHOKE_PHASE     = 6;
  localparam int                CHOKE_CYCLES    = 64;
  localparam pgh_pkg::cfg_idx_t UNMAPPED_REG    = 4'd11;

  logic              clk;
  logic              rst        = 1'b1;
  logic              pcl_valid  = 1'b0;
  logic              pcl_stall;
  logic [31:0]       pos_x      = '0;
  logic [31:0]       pos_y      = '0;
  logic [31:0]       pos_z      = '0;
  logic [31:0]       life_in    = '0;
  logic              hash_valid;
  logic              hash_stall = 1'b0;
  logic [31:0]       cell_hash;
  logic [30:0]       life_out;
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  pgh_pkg::cfg_idx_t cfg_index  = '0;
  logic [31:0]       cfg_data   = '0;

  int   mismatches;
  int   pending_hashes;
  int   send_idle_pct = 13;
  int   recv_idle_pct = 83;
  logic choke_armed   = 1'b0;

  particle_grid_hash dut (
    .clk        (clk),
    .rst        (rst),
    .pcl_valid  (pcl_valid),
    .pcl_stall  (pcl_stall),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .life_in    (life_in),
    .hash_valid (hash_valid),
    .hash_stall (hash_stall),
    .cell_hash  (cell_hash),
    .life_out   (life_out),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  particle_grid_hash_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .pcl_valid      (pcl_valid),
    .pcl_stall      (pcl_stall),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .pos_z          (pos_z),
    .life_in        (life_in),
    .hash_valid     (hash_valid),
    .hash_stall     (hash_stall),
    .cell_hash      (cell_hash),
    .life_out       (life_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatches),
    .pending_hashes (pending_hashes)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off when armed.
  initial begin
    forever begin
      @(posedge clk);
      if (choke_armed) begin
        choke_armed = 1'b0;
        hash_stall <= 1'b1;
        for (int i = 0; i < CHOKE_CYCLES; i++) @(posedge clk);
      end else begin
        hash_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Random word spread over all magnitudes, both signs.
  function automatic logic [31:0] spread_rand();
    return $unsigned($signed($urandom) >>> $urandom_range(0, 31));
  endfunction

  function automatic pgh_pkg::cfg_regs_t make_cfg(
    input logic [31:0] ox, input logic [31:0] oy,
    input logic [31:0] oz, input logic [31:0] ix,
    input logic [31:0] iy, input logic [31:0] iz,
    input logic [11:0] bits, input logic [30:0] step);
    pgh_pkg::cfg_regs_t c;
    c.origin_x   = ox;
    c.origin_y   = oy;
    c.origin_z   = oz;
    c.inv_cell_x = ix;
    c.inv_cell_y = iy;
    c.inv_cell_z = iz;
    c.axis_bits  = bits;
    c.time_step  = step;
    return c;
  endfunction

  // One register write transaction; valid stays up for a following write.
  task automatic write_reg(input pgh_pkg::cfg_idx_t idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Write every register, with junk in unused upper bits and one stray index.
  task automatic load_config(input pgh_pkg::cfg_regs_t c);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(pgh_pkg::REG_ORIGIN_X, c.origin_x);
    write_reg(pgh_pkg::REG_ORIGIN_Y, c.origin_y);
    write_reg(pgh_pkg::REG_ORIGIN_Z, c.origin_z);
    write_reg(pgh_pkg::REG_INV_CELL_X, c.inv_cell_x);
    write_reg(pgh_pkg::REG_INV_CELL_Y, c.inv_cell_y);
    write_reg(pgh_pkg::REG_INV_CELL_Z, c.inv_cell_z);
    write_reg(pgh_pkg::REG_AXIS_BITS, {junk[19:0], c.axis_bits});
    write_reg(pgh_pkg::REG_TIME_STEP, {junk[31], c.time_step});
    write_reg(UNMAPPED_REG, $urandom);
    cfg_valid <= 1'b0;
  endtask

  // One particle transaction, after a random number of idle cycles.
  task automatic send_particle(input logic [31:0] px, input logic [31:0] py,
                               input logic [31:0] pz, input logic [31:0] life);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pcl_valid <= 1'b0;
      @(posedge clk);
    end
    pcl_valid <= 1'b1;
    pos_x     <= px;
    pos_y     <= py;
    pos_z     <= pz;
    life_in   <= life;
    @(posedge clk);
    while (pcl_stall) @(posedge clk);
  endtask

  // Mostly positions near the grid, one lifetime in four near the step, some noise.
  task automatic random_particle(input pgh_pkg::cfg_regs_t c);
    logic [31:0] px, py, pz, life;
    px = ($urandom_range(0, 7) == 0) ? $urandom : c.origin_x + spread_rand();
    py = ($urandom_range(0, 7) == 0) ? $urandom : c.origin_y + spread_rand();
    pz = ($urandom_range(0, 7) == 0) ? $urandom : c.origin_z + spread_rand();
    if ($urandom_range(0, 3) == 0) begin
      life = {1'b0, c.time_step} + $urandom_range(0, 4) - 32'd2;
    end else begin
      life = spread_rand();
    end
    send_particle(px, py, pz, life);
  endtask

  // Stop offering and let every owed hash come out before touching registers.
  task automatic wait_drained();
    pcl_valid <= 1'b0;
    @(posedge clk);
    while (pending_hashes != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    pgh_pkg::cfg_regs_t setting;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset register values: zero axis widths, so only the dead flag shows.
    send_particle(32'h0005_0000, 32'h0001_0000, 32'h7FFF_FFFF, 32'h0001_0000);
    send_particle(32'h8000_0000, 32'h0, 32'h1, 32'h0);
    send_particle(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    wait_drained();

    // Unit cells, full ten-bit axes, one-unit time step.
    setting = make_cfg(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000,
                       32'h0001_0000, 12'hAAA, 31'h0001_0000);
    load_config(setting);
    send_particle(32'h0005_0000, 32'h0007_0000, 32'h0009_8000, 32'h0003_0000);
    send_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_particle(32'h0, 32'h0, 32'h0, 32'h0001_0000);
    send_particle(32'h1, 32'h0000_FFFF, 32'h0001_0000, 32'h0001_0001);
    send_particle(32'h03FF_0000, 32'h0400_0000, 32'h03FF_FFFF, 32'h0000_FFFF);
    send_particle(32'hFFFF_0000, 32'h0002_0000, 32'h0001_0000, 32'hFFFF_FFFF);
    wait_drained();

    // Extreme origins and reciprocals, oversized axis fields, largest step.
    setting = make_cfg(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0,
                       32'h1, 12'hFFF, 31'h7FFF_FFFF);
    load_config(setting);
    send_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_particle(32'h8000_0001, 32'h0, 32'h0001_0000, 32'h0);
    send_particle(32'h0, 32'hFFFF_FFFF, 32'h7FFF_0000, 32'h7FFF_FFFE);
    wait_drained();

    // Zero-width x axis, clamped z field, narrow y axis, zero step.
    setting = make_cfg(32'hFFF0_0000, 32'h0010_0000, 32'h0, 32'h0000_8000,
                       32'h0002_0000, 32'h0010_0000, 12'h3C0, 31'h0);
    load_config(setting);
    send_particle(32'h0, 32'h0014_0000, 32'h0000_8000, 32'h0);
    send_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001);
    send_particle(32'hFFF0_0000, 32'h0010_0001, 32'h0000_1000, 32'h8000_0000);
    wait_drained();

    // Random settings; pacing goes slow receiver, then slow sender, then none.
    for (int ph = 0; ph < PHASES; ph++) begin
      send_idle_pct = (ph < 3) ? 13 : (ph < 6) ? 83 : 0;
      recv_idle_pct = (ph < 3) ? 83 : (ph < 6) ? 13 : 0;
      setting = make_cfg(spread_rand(), spread_rand(), spread_rand(),
                         $urandom >> $urandom_range(0, 31),
                         $urandom >> $urandom_range(0, 31),
                         $urandom >> $urandom_range(0, 31),
                         12'($urandom_range(0, 4095)),
                         31'($urandom >> $urandom_range(1, 31)));
      load_config(setting);
      if (ph == CHOKE_PHASE) choke_armed = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) random_particle(setting);
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
